/* src/b64d_pkg.sv */
// Shared types, codes and the character lookup for the streaming Base64 decoder.
// Used by b64d_core, b64d_result_fifo, base64_decoder_stream, b64d_stream_checker and the testbench; no dependencies.
`default_nettype none

package b64d_pkg;

    localparam int CAP_W       = 24;
    localparam int TOTAL_W     = 25;
    localparam int PARTIAL_W   = 18;
    localparam int RES_MAX     = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    // lookup codes besides the 64 alphabet values
    localparam logic [6:0] SKIP_CODE = 7'd64;
    localparam logic [6:0] PAD_CODE  = 7'd65;
    localparam logic [6:0] BAD_CODE  = 7'd66;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOROOM  = 2'd2;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic                 is_status;
        logic [7:0]           data_byte;
        logic [1:0]           status;
        logic [TOTAL_W-1:0]   byte_count;
        logic                 last_of_run;
    } result_t;

    typedef result_t [RES_MAX-1:0] result_set_t;

    // results produced by one item, slot 0 first
    typedef struct packed {
        logic [1:0]  n;
        result_set_t items;
    } push_t;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        begin
            if (c >= 8'h41 && c <= 8'h5a) begin
                v = 7'(c - 8'h41);
            end else if (c >= 8'h61 && c <= 8'h7a) begin
                v = 7'(c - 8'h61 + 8'd26);
            end else if (c >= 8'h30 && c <= 8'h39) begin
                v = 7'(c - 8'h30 + 8'd52);
            end else if (c == 8'h2b) begin
                v = 7'd62;
            end else if (c == 8'h2f) begin
                v = 7'd63;
            end else if (c == 8'h0a) begin
                v = SKIP_CODE;
            end else if (c == 8'h3d) begin
                v = PAD_CODE;
            end else begin
                v = BAD_CODE;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

/* src/base64_decoder_stream.sv */
// Top level of the streaming Base64 decoder: input register, capacity register,
// decode core and result queue. Depends on b64d_pkg, b64d_core, b64d_result_fifo.
//
// Usage:
//   Input channel (in_valid / in_stall, kind, code_char): one character word per
//   cycle while in_stall is low, or an end word (kind = 1) that closes the stream.
//   Output channel (out_valid / out_stall): data bytes, then one status word per
//   stream carrying status and byte_count; last_of_run marks the final result
//   of each input word.
//   Config channel (cfg_valid / cfg_ready, cfg_data): writes out_capacity;
//   cfg_ready is always high. Write it only while the block is idle.
// A word in the input register is decoded once the result queue has room; its results
//   go into the queue, whose head drives the output port. Throughput: one input word
//   per cycle while in_stall is low, one result word per cycle while out_stall is low;
//   the output port is the limit when groups emit three bytes. The input register
//   advances while the 8-entry result queue has room for three more results.
// Reset: clears stream state and the queue, out_capacity returns to 16777215.
// Output stall: results wait in the queue; once it lacks room for three more, in_stall rises.
`default_nettype none

module base64_decoder_stream (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          in_valid,
    output logic         in_stall,
    input  wire          kind,
    input  wire  [7:0]   code_char,
    output logic         out_valid,
    input  wire          out_stall,
    output logic         is_status,
    output logic [7:0]   data_byte,
    output logic [1:0]   status,
    output logic [24:0]  byte_count,
    output logic         last_of_run,
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [23:0]  cfg_data
);
    import b64d_pkg::*;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_kind_reg;
    logic [7:0]        s1_char_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic              go;
    logic              room;
    logic              pop;
    push_t             push;
    result_t           head;

    assign cfg_ready = 1'b1;
    assign go        = s1_valid_reg && room;
    assign in_stall  = s1_valid_reg && !room;
    assign pop       = out_valid && !out_stall;

    assign s1_valid_next = in_stall ? s1_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            cap_reg      <= {CAP_W{1'b1}};
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            s1_kind_reg <= kind;
            s1_char_reg <= code_char;
        end
    end

    b64d_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (go),
        .kind         (s1_kind_reg),
        .code_char    (s1_char_reg),
        .out_capacity (cap_reg),
        .push         (push)
    );

    b64d_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .room      (room)
    );

    assign is_status   = head.is_status;
    assign data_byte   = head.data_byte;
    assign status      = head.status;
    assign byte_count  = head.byte_count;
    assign last_of_run = head.last_of_run;

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status |-> last_of_run)
        else $error("status word without last_of_run");

    a_held_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> s1_valid_reg && $stable(s1_kind_reg) && $stable(s1_char_reg))
        else $error("stalled input register changed");

endmodule

`default_nettype wire

/* src/b64d_core.sv */
// Decode state and per-word step logic: sextet accumulation, flush, capacity checks.
// Depends on b64d_pkg.
`default_nettype none

module b64d_core (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         go,
    input  wire                         kind,
    input  wire  [7:0]                  code_char,
    input  wire  [b64d_pkg::CAP_W-1:0]  out_capacity,
    output b64d_pkg::push_t             push
);
    import b64d_pkg::*;

    logic [PARTIAL_W-1:0] partial_reg, partial_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 pad_reg, pad_next;
    logic [1:0]           err_reg, err_next;

    logic [6:0]           v;
    logic [23:0]          w;
    logic [TOTAL_W-1:0]   tot_v;
    logic [1:0]           err_v;
    logic [1:0]           nb;
    logic [TOTAL_W:0]     term_sum;
    logic [TOTAL_W-1:0]   cap_ext;

    assign cap_ext = {1'b0, out_capacity};

    function automatic result_t data_res(input logic [7:0] b, input logic last);
        result_t r;
        begin
            r             = '0;
            r.data_byte   = b;
            r.last_of_run = last;
            return r;
        end
    endfunction

    always_comb
    begin
        partial_next = partial_reg;
        cnt_next     = cnt_reg;
        total_next   = total_reg;
        pad_next     = pad_reg;
        err_next     = err_reg;
        push         = '0;
        v            = sextet_of(code_char);
        w            = {partial_reg, v[5:0]};
        tot_v        = total_reg;
        err_v        = err_reg;
        nb           = 2'd0;
        term_sum     = '0;
        if (go) begin
            if (kind == KIND_CHAR) begin
                if (err_reg == ST_OK && !pad_reg) begin
                    if (v == SKIP_CODE) begin
                        // line feed: nothing to do
                    end else if (v == PAD_CODE) begin
                        pad_next = 1'b1;
                    end else if (v == BAD_CODE) begin
                        err_next = ST_INVALID;
                    end else if (cnt_reg != 2'd3) begin
                        partial_next = {partial_reg[PARTIAL_W-7:0], v[5:0]};
                        cnt_next     = cnt_reg + 2'd1;
                    end else begin
                        partial_next = '0;
                        cnt_next     = 2'd0;
                        tot_v        = total_reg + TOTAL_W'(3);
                        total_next   = tot_v;
                        if (tot_v > cap_ext) begin
                            err_next = ST_NOROOM;
                        end else begin
                            push.items[0] = data_res(w[23:16], 1'b0);
                            push.items[1] = data_res(w[15:8], 1'b0);
                            push.items[2] = data_res(w[7:0], 1'b1);
                            push.n        = 2'd3;
                        end
                    end
                end
            end else begin
                if (err_reg == ST_OK) begin
                    if (cnt_reg == 2'd3) begin
                        tot_v = total_reg + TOTAL_W'(2);
                        if (tot_v > cap_ext) begin
                            err_v = ST_NOROOM;
                        end else begin
                            push.items[0] = data_res(partial_reg[17:10], 1'b0);
                            push.items[1] = data_res(partial_reg[9:2], 1'b0);
                            nb            = 2'd2;
                        end
                    end else if (cnt_reg == 2'd2) begin
                        tot_v = total_reg + TOTAL_W'(1);
                        if (tot_v > cap_ext) begin
                            err_v = ST_NOROOM;
                        end else begin
                            push.items[0] = data_res(partial_reg[11:4], 1'b0);
                            nb            = 2'd1;
                        end
                    end
                    // room for the terminator slot
                    term_sum = {1'b0, tot_v} + (TOTAL_W + 1)'(1);
                    if (err_v == ST_OK && term_sum > {1'b0, cap_ext}) begin
                        err_v = ST_NOROOM;
                    end
                end
                unique case (nb)
                    2'd0:    push.items[0] = '{1'b1, 8'd0, err_v, tot_v, 1'b1};
                    2'd1:    push.items[1] = '{1'b1, 8'd0, err_v, tot_v, 1'b1};
                    default: push.items[2] = '{1'b1, 8'd0, err_v, tot_v, 1'b1};
                endcase
                push.n       = nb + 2'd1;
                partial_next = '0;
                cnt_next     = 2'd0;
                total_next   = '0;
                pad_next     = 1'b0;
                err_next     = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            partial_reg <= '0;
            cnt_reg     <= 2'd0;
            total_reg   <= '0;
            pad_reg     <= 1'b0;
            err_reg     <= ST_OK;
        end else begin
            partial_reg <= partial_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            pad_reg     <= pad_next;
            err_reg     <= err_next;
        end
    end

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && kind == KIND_END |=> cnt_reg == 2'd0 && total_reg == '0 && err_reg == ST_OK)
        else $error("end word did not clear the stream state");

    a_err_blocks_data: assert property (@(posedge clk) disable iff (!rst_n)
        go && kind == KIND_CHAR && err_reg != ST_OK |-> push.n == 2'd0 && err_next == err_reg)
        else $error("character accepted after a latched error");

endmodule

`default_nettype wire

/* src/b64d_result_fifo.sv */
// Result queue: takes up to three result words per cycle, hands out one per cycle.
// Depends on b64d_pkg.
`default_nettype none

module b64d_result_fifo (
    input  wire              clk,
    input  wire              rst_n,
    input  b64d_pkg::push_t  push,
    input  wire              pop,
    output b64d_pkg::result_t head,
    output logic             not_empty,
    output logic             room
);
    import b64d_pkg::*;

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // space for a full set of results from the next word
    assign room      = (count_reg <= FIFO_CW'(FIFO_DEPTH - RES_MAX));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.n);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + FIFO_CW'(push.n) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++) begin
            if (2'(i) < push.n) begin
                mem_reg[wr_ptr_reg + FIFO_AW'(i)] <= push.items[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> FIFO_CW'(push.n) + count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("result queue read while empty");

endmodule

`default_nettype wire

/* verif/b64d_stream_checker.sv */
// Checker for base64_decoder_stream: watches the input, output and capacity channels,
// predicts every result word and compares it field by field. Depends on b64d_pkg.
module b64d_stream_checker (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          in_valid,
    input  wire          in_stall,
    input  wire          kind,
    input  wire  [7:0]   code_char,
    input  wire          out_valid,
    input  wire          out_stall,
    input  wire          is_status,
    input  wire  [7:0]   data_byte,
    input  wire  [1:0]   status,
    input  wire  [24:0]  byte_count,
    input  wire          last_of_run,
    input  wire          cfg_valid,
    input  wire          cfg_ready,
    input  wire  [23:0]  cfg_data,
    output int           mismatches,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import b64d_pkg::*;

    // decoder state as the predictor sees it
    logic [CAP_W-1:0]     capacity;
    logic [PARTIAL_W-1:0] sextets;
    logic [1:0]           sextets_held;
    logic [TOTAL_W-1:0]   total_bytes;
    logic                 pad_seen;
    logic [1:0]           stream_err;

    result_t decoded_q[$];
    result_t want;

    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [6:0] v;
        if (c >= "A" && c <= "Z")
        begin
            v = 7'(c - 8'h41);
        end
        else if (c >= "a" && c <= "z")
        begin
            v = 7'(c - 8'h61 + 8'd26);
        end
        else if (c >= "0" && c <= "9")
        begin
            v = 7'(c - 8'h30 + 8'd52);
        end
        else if (c == "+")
        begin
            v = 7'd62;
        end
        else if (c == "/")
        begin
            v = 7'd63;
        end
        else if (c == 8'h0a)
        begin
            v = SKIP_CODE;
        end
        else if (c == "=")
        begin
            v = PAD_CODE;
        end
        else
        begin
            v = BAD_CODE;
        end
        return v;
    endfunction

    // counts n more bytes; false once they no longer fit the destination
    function automatic bit claim_bytes(input int unsigned n);
        total_bytes = TOTAL_W'(total_bytes + n);
        if (total_bytes > {1'b0, capacity})
        begin
            stream_err = ST_NOROOM;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last);
        result_t r;
        r = '0;
        r.data_byte = b;
        r.last_of_run = last;
        decoded_q.push_back(r);
    endtask

    task automatic clear_stream();
        sextets = '0;
        sextets_held = '0;
        total_bytes = '0;
        pad_seen = 1'b0;
        stream_err = ST_OK;
    endtask

    task automatic decode_word(input logic k, input logic [7:0] c);
        logic [6:0]  v;
        logic [23:0] grp;
        result_t     r;
        if (k == KIND_CHAR)
        begin
            if (stream_err != ST_OK || pad_seen)
                return;
            v = char_to_sextet(c);
            if (v == SKIP_CODE)
                return;
            if (v == PAD_CODE)
            begin
                pad_seen = 1'b1;
                return;
            end
            if (v == BAD_CODE)
            begin
                stream_err = ST_INVALID;
                return;
            end
            if (sextets_held != 2'd3)
            begin
                sextets = {sextets[11:0], v[5:0]};
                sextets_held = sextets_held + 2'd1;
                return;
            end
            grp = {sextets, v[5:0]};
            sextets = '0;
            sextets_held = '0;
            if (claim_bytes(3))
            begin
                push_byte(grp[23:16], 1'b0);
                push_byte(grp[15:8], 1'b0);
                push_byte(grp[7:0], 1'b1);
            end
        end
        else
        begin
            if (stream_err == ST_OK)
            begin
                if (sextets_held == 2'd3)
                begin
                    if (claim_bytes(2))
                    begin
                        push_byte(sextets[17:10], 1'b0);
                        push_byte(sextets[9:2], 1'b0);
                    end
                end
                else if (sextets_held == 2'd2)
                begin
                    if (claim_bytes(1))
                        push_byte(sextets[11:4], 1'b0);
                end
                // room for the terminator slot
                if (stream_err == ST_OK && 26'(total_bytes) + 26'd1 > 26'(capacity))
                    stream_err = ST_NOROOM;
            end
            r = '0;
            r.is_status = 1'b1;
            r.status = stream_err;
            r.byte_count = total_bytes;
            r.last_of_run = 1'b1;
            decoded_q.push_back(r);
            clear_stream();
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v,
                     got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = 24'hFFFFFF;
            clear_stream();
            decoded_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            // results first: a word accepted now cannot have a result yet
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t ns: unexpected word, expected none actual %0h/%0h/%0h/%0h/%0h",
                             $time, is_status, data_byte, status, byte_count, last_of_run);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("is_status", want.is_status, is_status);
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("status", want.status, status);
                    check_field("byte_count", want.byte_count, byte_count);
                    check_field("last_of_run", want.last_of_run, last_of_run);
                end
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (in_valid && !in_stall)
                decode_word(kind, code_char);
            pending = decoded_q.size();
        end
    end

endmodule

/* verif/tb_base64_decoder_stream.sv */
// Testbench top for base64_decoder_stream: clock, reset, character stimulus,
// capacity writes and output stalls. Depends on b64d_pkg and b64d_stream_checker.
module tb_base64_decoder_stream;
    timeunit 1ns;
    timeprecision 1ps;
    import b64d_pkg::*;

    localparam int NUM_PHASES = 8;
    localparam int PHASE_WORDS = 35;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         in_valid = 1'b0;
    logic         kind = 1'b0;
    logic [7:0]   code_char = 8'h00;
    logic         out_stall = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [23:0]  cfg_data = 24'h000000;
    wire          in_stall;
    wire          out_valid;
    wire          is_status;
    wire  [7:0]   data_byte;
    wire  [1:0]   status;
    wire  [24:0]  byte_count;
    wire          last_of_run;
    wire          cfg_ready;

    int mismatches;
    int pending;
    int words_sent = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    base64_decoder_stream dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .code_char   (code_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_status   (is_status),
        .data_byte   (data_byte),
        .status      (status),
        .byte_count  (byte_count),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    b64d_stream_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .code_char   (code_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_status   (is_status),
        .data_byte   (data_byte),
        .status      (status),
        .byte_count  (byte_count),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL base64_decoder_stream");
        $finish;
    end

    // receiver: random stall bursts, or one long hold when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] alpha_char(input int unsigned idx);
        if (idx < 26)
            return 8'(8'h41 + idx);
        if (idx < 52)
            return 8'(8'h61 + idx - 26);
        if (idx < 62)
            return 8'(8'h30 + idx - 52);
        return (idx == 62) ? "+" : "/";
    endfunction

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_word(input logic k, input logic [7:0] c);
        if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            kind <= 1'($urandom);
            code_char <= 8'($urandom);
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        code_char <= c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(KIND_CHAR, s[i]);
    endtask

    // one encoded text and its end word; mostly well formed, some with noise
    task automatic send_stream(input int min_groups, input int max_groups);
        int  groups;
        int  tail;
        bit  noisy;
        groups = $urandom_range(min_groups, max_groups);
        tail = $urandom_range(0, 3);
        noisy = ($urandom_range(0, 9) < 2);
        for (int i = 0; i < groups * 4 + tail; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(KIND_CHAR, 8'h0a);
            if (noisy && $urandom_range(0, 9) == 0)
                send_word(KIND_CHAR, 8'($urandom_range(0, 255)));
            else
                send_word(KIND_CHAR, alpha_char($urandom_range(0, 63)));
        end
        if (tail == 2)
            send_text("==");
        else if (tail == 3 || (noisy && $urandom_range(0, 1) == 0))
            send_text("=");
        if (noisy)
        begin
            // anything after padding is dropped
            repeat ($urandom_range(0, 3))
                send_word(KIND_CHAR, 8'($urandom_range(0, 255)));
        end
        send_word(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    // let every expected word come out and the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [23:0] cap);
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [23:0] cap;
        int          phase_start;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 20;
        stall_pct = 20;
        // full group, line feed, alphabet extremes, pad then ignored junk
        send_text("TWFu\nAz09+/=!");
        send_word(KIND_END, 8'hff);
        // lone sextet dropped
        send_text("A");
        send_word(KIND_END, 8'h00);
        // three sextets flush two bytes
        send_text("abc");
        send_word(KIND_END, 8'h5a);
        // invalid character latches, later characters ignored
        send_text("*Q");
        send_word(KIND_END, 8'h0f);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0: cap = 24'd0;
                1: cap = 24'd1;
                2: cap = 24'd2;
                3: cap = 24'd3;
                4: cap = 24'd5;
                5: cap = 24'($urandom_range(6, 40));
                6: cap = 24'($urandom_range(1000, 16777214));
                default: cap = 24'hFFFFFF;
            endcase
            write_capacity(cap);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            if (ph == 6)
            begin
                // long output hold while input keeps coming, fills the result queue
                hold_cycles = 300;
                send_stream(8, 10);
                send_stream(8, 10);
            end
            if (ph == NUM_PHASES - 1)
            begin
                stall_pct = 0;
                gap_pct = 0;
            end
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
                send_stream(0, 5);
        end
        drain();

        if (mismatches == 0 && pending == 0)
        begin
            $display("PASS base64_decoder_stream");
        end
        else
        begin
            $display("FAIL base64_decoder_stream");
        end
        $finish;
    end

endmodule
